// File: rtl/hough_line_accumulator_core_macros.svh
// Assertion macros shared by the accumulator RTL.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef HOUGH_LINE_ACCUMULATOR_CORE_MACROS_SVH
`define HOUGH_LINE_ACCUMULATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The expression must never be true outside reset.
`define HLA_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

// File: rtl/hla_pkg.sv
package hla_pkg;

   // Default sizes of the stores.
   localparam int DEF_MAX_ANGLES   = 256;
   localparam int DEF_MAX_RHO_BINS = 1024;
   localparam int DEF_COUNT_BITS   = 16;

   // Pixels at or beyond this column or row are ignored.
   localparam int IMAGE_SIDE = 512;

   // Q1.14 arithmetic.
   localparam int Q_FRAC_BITS = 14;
   localparam int Q_HALF      = 8192;
   localparam int PROD_BITS   = 26;
   // Wide enough for both products plus the largest offset (up to 4096 bins).
   localparam int SUM_BITS    = 28;
   localparam int BIN_BITS    = SUM_BITS - 1 - Q_FRAC_BITS;
   localparam logic signed [SUM_BITS-1:0] Q_ONE_NEG = SUM_BITS'(-16384);

   // Field widths of the result word.
   localparam int COUNT_OUT_BITS = 16;
   localparam int DROP_BITS      = 9;

   // Table memory holds cosine in the upper half and sine in the lower half.
   localparam int TABLE_WIDTH = 32;

   // Register file.
   localparam int PADDR_BITS = 3;
   localparam logic REG_ANGLES   = 1'b0;
   localparam logic REG_RHO_BINS = 1'b1;
   localparam logic [8:0]  ANGLES_RESET   = 9'd180;
   localparam logic [10:0] RHO_BINS_RESET = 11'd1024;

   // Command codes of the request word.
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_VOTE  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         angle_index;
      logic signed [15:0] cos_value;
      logic signed [15:0] sin_value;
      logic [8:0]         col;
      logic [8:0]         row;
      logic               lit;
      logic [9:0]         rho_index;
   } req_type;

   typedef struct packed {
      logic [COUNT_OUT_BITS-1:0] count;
      logic [DROP_BITS-1:0]      dropped_votes;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_VOTE,
      ST_READ,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic load_table;
      logic issue;
      logic rd_issue;
      logic rd_capture;
      logic sweep_step;
      logic result_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic angles_left;
      logic pipe_busy;
      logic sweep_last;
      logic out_free;
   } ctrl_stat_type;

endpackage

// File: rtl/hla_ram.sv
module hla_ram #(
   parameter int WIDTH = hla_pkg::TABLE_WIDTH,
   parameter int DEPTH = hla_pkg::DEF_MAX_ANGLES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/hla_ctrl.sv
module hla_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_ready,
   input  hla_pkg::ctrl_stat_type ctrl_stat,
   output hla_pkg::ctrl_cmd_type  ctrl_cmd
);

   hla_pkg::state_type state_ff;
   hla_pkg::state_type state_in;
   logic               accept;

   assign req_ready = (state_ff == hla_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hla_pkg::ST_INIT: begin
            if (ctrl_stat.sweep_last) begin
               state_in = hla_pkg::ST_IDLE;
            end
         end
         hla_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  hla_pkg::CMD_LOAD:  state_in = hla_pkg::ST_FINISH;
                  hla_pkg::CMD_VOTE:  state_in = hla_pkg::ST_VOTE;
                  hla_pkg::CMD_READ:  state_in = hla_pkg::ST_READ;
                  hla_pkg::CMD_CLEAR: state_in = hla_pkg::ST_CLEAR;
                  default:            state_in = hla_pkg::ST_FINISH;
               endcase
            end
         end
         hla_pkg::ST_CLEAR: begin
            if (ctrl_stat.sweep_last) begin
               state_in = hla_pkg::ST_FINISH;
            end
         end
         hla_pkg::ST_VOTE: begin
            if (!ctrl_stat.angles_left && !ctrl_stat.pipe_busy) begin
               state_in = hla_pkg::ST_FINISH;
            end
         end
         hla_pkg::ST_READ:      state_in = hla_pkg::ST_READ_WAIT;
         hla_pkg::ST_READ_WAIT: state_in = hla_pkg::ST_FINISH;
         hla_pkg::ST_FINISH: begin
            if (ctrl_stat.out_free) begin
               state_in = hla_pkg::ST_IDLE;
            end
         end
         default: state_in = hla_pkg::ST_INIT;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      ctrl_cmd             = '0;
      ctrl_cmd.capture     = accept;
      ctrl_cmd.load_table  = accept && (req_cmd == hla_pkg::CMD_LOAD);
      case (state_ff)
         hla_pkg::ST_INIT:      ctrl_cmd.sweep_step  = 1'b1;
         hla_pkg::ST_CLEAR:     ctrl_cmd.sweep_step  = 1'b1;
         hla_pkg::ST_VOTE:      ctrl_cmd.issue       = ctrl_stat.angles_left;
         hla_pkg::ST_READ:      ctrl_cmd.rd_issue    = 1'b1;
         hla_pkg::ST_READ_WAIT: ctrl_cmd.rd_capture  = 1'b1;
         hla_pkg::ST_FINISH:    ctrl_cmd.result_load = ctrl_stat.out_free;
         default:               ctrl_cmd.sweep_step  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hla_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/hla_datapath.sv
`include "hough_line_accumulator_core_macros.svh"

module hla_datapath #(
   parameter int MAX_ANGLES   = hla_pkg::DEF_MAX_ANGLES,
   parameter int MAX_RHO_BINS = hla_pkg::DEF_MAX_RHO_BINS,
   parameter int COUNT_BITS   = hla_pkg::DEF_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [8:0]             angles_in_use,
   input  logic [10:0]            rho_bins_in_use,
   input  hla_pkg::req_type       req_data,
   input  hla_pkg::ctrl_cmd_type  ctrl_cmd,
   output hla_pkg::ctrl_stat_type ctrl_stat,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output hla_pkg::rsp_type       rsp_data
);

   localparam int ANGLE_BITS     = (MAX_ANGLES > 1) ? $clog2(MAX_ANGLES) : 1;
   localparam int ANGLE_CNT_BITS = $clog2(MAX_ANGLES + 1);
   localparam int RHO_BITS       = $clog2(MAX_RHO_BINS);
   localparam int RHO_CNT_BITS   = $clog2(MAX_RHO_BINS + 1);
   localparam int CTR_ADDR_BITS  = RHO_BITS + ANGLE_BITS;
   localparam int TABLE_DEPTH    = 2 ** ANGLE_BITS;
   localparam int CTR_DEPTH      = 2 ** CTR_ADDR_BITS;
   localparam int SUM_BITS       = hla_pkg::SUM_BITS;
   localparam int PROD_BITS      = hla_pkg::PROD_BITS;
   localparam int BIN_BITS       = hla_pkg::BIN_BITS;

   // Effective angle and bin counts after saturation.
   logic [ANGLE_CNT_BITS-1:0] na;
   logic [RHO_CNT_BITS-1:0]   nr;

   assign na = (32'(angles_in_use) > 32'(MAX_ANGLES)) ? ANGLE_CNT_BITS'(MAX_ANGLES)
                                                      : ANGLE_CNT_BITS'(angles_in_use);
   assign nr = (32'(rho_bins_in_use) > 32'(MAX_RHO_BINS)) ? RHO_CNT_BITS'(MAX_RHO_BINS)
                                                          : RHO_CNT_BITS'(rho_bins_in_use);

   // Captured request word.
   logic [8:0]               col_ff;
   logic [8:0]               row_ff;
   logic                     vote_ok_ff;
   logic                     vote_ok_in;
   logic                     rd_ok_ff;
   logic                     rd_ok_in;
   logic [CTR_ADDR_BITS-1:0] rd_addr_ff;

   assign vote_ok_in = req_data.lit
                    && (32'(req_data.col) < 32'(hla_pkg::IMAGE_SIDE))
                    && (32'(req_data.row) < 32'(hla_pkg::IMAGE_SIDE));
   assign rd_ok_in   = (32'(req_data.rho_index) < 32'(MAX_RHO_BINS))
                    && (32'(req_data.angle_index) < 32'(MAX_ANGLES));

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         col_ff     <= req_data.col;
         row_ff     <= req_data.row;
         rd_ok_ff   <= rd_ok_in;
         rd_addr_ff <= {RHO_BITS'(req_data.rho_index), ANGLE_BITS'(req_data.angle_index)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vote_ok_ff <= 1'b0;
      end else if (ctrl_cmd.capture) begin
         vote_ok_ff <= vote_ok_in;
      end
   end

   // Angle table: cosine and sine share one word.
   logic                         tbl_wr_en;
   logic [ANGLE_BITS-1:0]        tbl_wr_addr;
   logic [hla_pkg::TABLE_WIDTH-1:0] tbl_rdata;
   logic [ANGLE_CNT_BITS-1:0]    a_ff;
   logic [ANGLE_CNT_BITS-1:0]    a_in;

   assign tbl_wr_en   = ctrl_cmd.load_table && (32'(req_data.angle_index) < 32'(MAX_ANGLES));
   assign tbl_wr_addr = ANGLE_BITS'(req_data.angle_index);

   hla_ram #(
      .WIDTH (hla_pkg::TABLE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data ({req_data.cos_value, req_data.sin_value}),
      .rd_en   (ctrl_cmd.issue),
      .rd_addr (ANGLE_BITS'(a_ff)),
      .rd_data (tbl_rdata)
   );

   // Angle issue counter: one angle enters the pipeline per cycle.
   always_comb begin
      a_in = a_ff;
      if (ctrl_cmd.capture) begin
         a_in = '0;
      end else if (ctrl_cmd.issue) begin
         a_in = a_ff + ANGLE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
      end else begin
         a_ff <= a_in;
      end
   end

   // Vote pipeline valid bits.
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s4_write_ff;
   logic hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_write_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl_cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_write_ff <= s3_valid_ff && hit;
      end
   end

   // Stage 2: the two products, from the table word read in stage 1.
   logic [ANGLE_BITS-1:0]       s1_ang_ff;
   logic [ANGLE_BITS-1:0]       s2_ang_ff;
   logic [ANGLE_BITS-1:0]       s3_ang_ff;
   logic signed [9:0]           col_s;
   logic signed [9:0]           row_s;
   logic signed [15:0]          cos_q;
   logic signed [15:0]          sin_q;
   logic signed [PROD_BITS-1:0] prod_cos_ff;
   logic signed [PROD_BITS-1:0] prod_sin_ff;
   logic signed [PROD_BITS-1:0] prod_cos_in;
   logic signed [PROD_BITS-1:0] prod_sin_in;

   assign col_s       = $signed({1'b0, col_ff});
   assign row_s       = $signed({1'b0, row_ff});
   assign cos_q       = $signed(tbl_rdata[31:16]);
   assign sin_q       = $signed(tbl_rdata[15:0]);
   assign prod_cos_in = col_s * cos_q;
   assign prod_sin_in = row_s * sin_q;

   always_ff @(posedge clock) begin
      s1_ang_ff   <= ANGLE_BITS'(a_ff);
      s2_ang_ff   <= s1_ang_ff;
      s3_ang_ff   <= s2_ang_ff;
      prod_cos_ff <= prod_cos_in;
      prod_sin_ff <= prod_sin_in;
   end

   // Stage 3: sum with the centre offset plus one half.
   logic [RHO_CNT_BITS+hla_pkg::Q_FRAC_BITS-2:0] base_u;
   logic signed [SUM_BITS-1:0] base_s;
   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [SUM_BITS-1:0] sum_in;

   assign base_u = {nr[RHO_CNT_BITS-1:1], hla_pkg::Q_FRAC_BITS'(hla_pkg::Q_HALF)};
   assign base_s = $signed(SUM_BITS'(base_u));
   assign sum_in = $signed({{(SUM_BITS-PROD_BITS){prod_cos_ff[PROD_BITS-1]}}, prod_cos_ff})
                 + $signed({{(SUM_BITS-PROD_BITS){prod_sin_ff[PROD_BITS-1]}}, prod_sin_ff})
                 + base_s;

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // Bin by truncation toward zero; a sum just below zero still lands in bin zero.
   logic                     sum_neg;
   logic [BIN_BITS-1:0]      bin_tz;
   logic [CTR_ADDR_BITS-1:0] vote_addr;
   logic [CTR_ADDR_BITS-1:0] s4_addr_ff;

   assign sum_neg   = sum_ff[SUM_BITS-1];
   assign bin_tz    = sum_neg ? '0 : sum_ff[SUM_BITS-2:hla_pkg::Q_FRAC_BITS];
   assign hit       = (!sum_neg || (sum_ff > hla_pkg::Q_ONE_NEG))
                   && (32'(bin_tz) < 32'(nr));
   assign vote_addr = {RHO_BITS'(bin_tz), s3_ang_ff};

   always_ff @(posedge clock) begin
      s4_addr_ff <= vote_addr;
   end

   // Votes that fall outside the bin range.
   logic [ANGLE_CNT_BITS-1:0] dropped_ff;

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         dropped_ff <= '0;
      end else if (s3_valid_ff && !hit) begin
         dropped_ff <= dropped_ff + ANGLE_CNT_BITS'(1);
      end
   end

   // Counter memory: read in stage 3, incremented and written back in stage 4.
   logic [CTR_ADDR_BITS-1:0] sweep_ff;
   logic                     ctr_rd_en;
   logic [CTR_ADDR_BITS-1:0] ctr_rd_addr;
   logic                     ctr_wr_en;
   logic [CTR_ADDR_BITS-1:0] ctr_wr_addr;
   logic [COUNT_BITS-1:0]    ctr_wr_data;
   logic [COUNT_BITS-1:0]    ctr_rdata;

   assign ctr_rd_en   = (s3_valid_ff && hit) || ctrl_cmd.rd_issue;
   assign ctr_rd_addr = ctrl_cmd.rd_issue ? rd_addr_ff : vote_addr;
   assign ctr_wr_en   = ctrl_cmd.sweep_step || s4_write_ff;
   assign ctr_wr_addr = ctrl_cmd.sweep_step ? sweep_ff : s4_addr_ff;
   assign ctr_wr_data = ctrl_cmd.sweep_step ? '0 : ctr_rdata + COUNT_BITS'(1);

   hla_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (CTR_DEPTH)
   ) u_counters (
      .clock   (clock),
      .wr_en   (ctr_wr_en),
      .wr_addr (ctr_wr_addr),
      .wr_data (ctr_wr_data),
      .rd_en   (ctr_rd_en),
      .rd_addr (ctr_rd_addr),
      .rd_data (ctr_rdata)
   );

   // Clearing sweep address; wraps back to zero after the last entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (ctrl_cmd.sweep_step) begin
         sweep_ff <= sweep_ff + CTR_ADDR_BITS'(1);
      end
   end

   // Counter value returned by a read.
   logic [hla_pkg::COUNT_OUT_BITS-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         count_ff <= '0;
      end else if (ctrl_cmd.rd_capture) begin
         count_ff <= rd_ok_ff ? hla_pkg::COUNT_OUT_BITS'(ctr_rdata) : '0;
      end
   end

   // Output register for the result word.
   logic             rsp_valid_ff;
   hla_pkg::rsp_type rsp_data_ff;
   hla_pkg::rsp_type rsp_data_in;

   assign rsp_data_in.count         = count_ff;
   assign rsp_data_in.dropped_votes = hla_pkg::DROP_BITS'(dropped_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.result_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status back to the controller.
   assign ctrl_stat.angles_left = vote_ok_ff && (a_ff < na);
   assign ctrl_stat.pipe_busy   = s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_write_ff;
   assign ctrl_stat.sweep_last  = &sweep_ff;
   assign ctrl_stat.out_free    = !rsp_valid_ff || rsp_ready;

   // The clearing sweep owns the write port alone.
   `HLA_ASSERT_NEVER(a_sweep_alone,
                     ctrl_cmd.sweep_step && (s4_write_ff || s1_valid_ff || ctrl_cmd.issue),
                     "clearing sweep overlaps a vote")
   // A result word is only formed once every vote has been written back.
   `HLA_ASSERT_IMPLY(a_result_after_drain, ctrl_cmd.result_load, !ctrl_stat.pipe_busy,
                     "result loaded while votes in flight")
   // A read result is taken in the cycle after its counter read.
   `HLA_ASSERT_IMPLY(a_read_latency, ctrl_cmd.rd_capture, $past(ctrl_cmd.rd_issue),
                     "read data taken without a read")

endmodule

// File: rtl/hough_line_accumulator_core.sv
// Hough line accumulator. Load words fill the per-angle cosine/sine table, vote words
// for a lit pixel add one, for every angle in use, to the counter of the bin it falls
// in (votes outside the bin range are counted as dropped), read words return one
// counter and clear words zero all counters; every request word yields one result word.
// Vote pipeline: one angle per cycle through the table read, the multipliers, the bin
// sum and a read-modify-write of the counter memory. Clearing writes one counter per
// cycle through the single write port, covering all 2**(clog2(MAX_RHO_BINS) +
// clog2(MAX_ANGLES)) entries (262144 at the default sizes); during a clear word, and
// the pass that follows reset, no request word is accepted; register writes are
// taken at any time.
module hough_line_accumulator_core #(
   parameter int MAX_ANGLES   = hla_pkg::DEF_MAX_ANGLES,
   parameter int MAX_RHO_BINS = hla_pkg::DEF_MAX_RHO_BINS,
   parameter int COUNT_BITS   = hla_pkg::DEF_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  hla_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output hla_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [hla_pkg::PADDR_BITS-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   // Configuration registers.
   logic [8:0]  angles_ff;
   logic [10:0] rho_bins_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         angles_ff   <= hla_pkg::ANGLES_RESET;
         rho_bins_ff <= hla_pkg::RHO_BINS_RESET;
      end else if (csr_write) begin
         if (paddr[2] == hla_pkg::REG_ANGLES) begin
            angles_ff <= pwdata[8:0];
         end
         if (paddr[2] == hla_pkg::REG_RHO_BINS) begin
            rho_bins_ff <= pwdata[10:0];
         end
      end
   end

   // Register read-back.
   always_comb begin
      case (paddr[2])
         hla_pkg::REG_ANGLES:   prdata = 32'(angles_ff);
         hla_pkg::REG_RHO_BINS: prdata = 32'(rho_bins_ff);
         default:               prdata = '0;
      endcase
   end

   hla_pkg::ctrl_cmd_type  ctrl_cmd;
   hla_pkg::ctrl_stat_type ctrl_stat;

   hla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .ctrl_stat (ctrl_stat),
      .ctrl_cmd  (ctrl_cmd)
   );

   hla_datapath #(
      .MAX_ANGLES   (MAX_ANGLES),
      .MAX_RHO_BINS (MAX_RHO_BINS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .angles_in_use   (angles_ff),
      .rho_bins_in_use (rho_bins_ff),
      .req_data        (req_data),
      .ctrl_cmd        (ctrl_cmd),
      .ctrl_stat       (ctrl_stat),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data)
   );

endmodule

// File: tb/hough_vote_checker.sv
module hough_vote_checker
   import hla_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int unsigned           awaiting,
   output int unsigned           mismatches
);

   localparam int unsigned TALLY_DEPTH = DEF_MAX_RHO_BINS * DEF_MAX_ANGLES;

   // Shadow copy of the registers, the angle table and the vote counters.
   logic [8:0]         angles_cfg;
   logic [10:0]        rho_cfg;
   logic signed [15:0] cos_tab [0:DEF_MAX_ANGLES-1];
   logic signed [15:0] sin_tab [0:DEF_MAX_ANGLES-1];
   bit [COUNT_OUT_BITS-1:0] tallies [0:TALLY_DEPTH-1];

   // Result words still owed by the block, oldest first.
   rsp_type     awaited_results [$];
   rsp_type     want;
   int unsigned errors = 0;

   function automatic void zero_tallies();
      for (int unsigned i = 0; i < TALLY_DEPTH; i++) begin
         tallies[i] = '0;
      end
   endfunction

   // Applies one request word to the shadow state and returns the result word it yields.
   function automatic rsp_type hough_outcome(req_type w);
      rsp_type     r;
      int unsigned n_ang;
      int unsigned n_rho;
      int unsigned missed;
      longint      unit;
      longint      centre;
      longint      s;
      longint      bin;
      r = '0;
      unit = longint'(1) << Q_FRAC_BITS;
      case (w.cmd)
         CMD_LOAD: begin
            cos_tab[w.angle_index] = w.cos_value;
            sin_tab[w.angle_index] = w.sin_value;
         end
         CMD_VOTE: begin
            if (w.lit && w.col < IMAGE_SIDE && w.row < IMAGE_SIDE) begin
               // Oversized register values saturate at the store sizes.
               n_ang = (angles_cfg > DEF_MAX_ANGLES) ? DEF_MAX_ANGLES : angles_cfg;
               n_rho = (rho_cfg > DEF_MAX_RHO_BINS) ? DEF_MAX_RHO_BINS : rho_cfg;
               centre = longint'(n_rho / 2) * unit + Q_HALF;
               missed = 0;
               for (int unsigned a = 0; a < n_ang; a++) begin
                  s = longint'(w.col) * longint'(cos_tab[a])
                      + longint'(w.row) * longint'(sin_tab[a]) + centre;
                  // Signed division truncates towards zero.
                  bin = s / unit;
                  if (bin < 0 || bin >= longint'(n_rho)) begin
                     missed++;
                  end else begin
                     tallies[bin * DEF_MAX_ANGLES + a] += 1'b1;
                  end
               end
               r.dropped_votes = DROP_BITS'(missed);
            end
         end
         CMD_READ: begin
            if (w.rho_index < DEF_MAX_RHO_BINS && w.angle_index < DEF_MAX_ANGLES) begin
               r.count = tallies[w.rho_index * DEF_MAX_ANGLES + w.angle_index];
            end
         end
         default: begin
            zero_tallies();
         end
      endcase
      return r;
   endfunction

   // Register writes, result comparison and prediction, all on the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         angles_cfg = ANGLES_RESET;
         rho_cfg = RHO_BINS_RESET;
         zero_tallies();
         awaited_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_ANGLES, 2'b00}) begin
               angles_cfg = pwdata[8:0];
            end else if (paddr == {REG_RHO_BINS, 2'b00}) begin
               rho_cfg = pwdata[10:0];
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result word, count %0d dropped %0d",
                        $time, rsp_data.count, rsp_data.dropped_votes);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.count !== want.count) begin
                  $display("%0t: count expected %0d, got %0d",
                           $time, want.count, rsp_data.count);
                  errors++;
               end
               if (rsp_data.dropped_votes !== want.dropped_votes) begin
                  $display("%0t: dropped_votes expected %0d, got %0d",
                           $time, want.dropped_votes, rsp_data.dropped_votes);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited_results.push_back(hough_outcome(req_data));
         end
      end
      awaiting <= awaited_results.size();
      mismatches <= errors;
   end

endmodule

// File: tb/tb_top.sv
module tb_top;
   import hla_pkg::*;

   // Covers the reset clearing pass, one clear word, every vote and the hold-offs.
   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [PADDR_BITS-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int unsigned awaiting;
   int unsigned mismatches;
   int unsigned cycle_count = 0;
   logic        no_idling = 1'b0;
   int unsigned stall_requests = 0;
   int unsigned stalls_served = 0;
   bit          loaded [0:DEF_MAX_ANGLES-1];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hough_line_accumulator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   hough_vote_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .awaiting   (awaiting),
      .mismatches (mismatches)
   );

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off each time one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall_requests > stalls_served) begin
            stalls_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= no_idling || ($urandom_range(99) >= 14);
         end
      end
   end

   function automatic req_type pack_word(logic [1:0] cmd, logic [7:0] ang,
                                         logic [15:0] cosv, logic [15:0] sinv,
                                         logic [8:0] col, logic [8:0] row,
                                         logic lit, logic [9:0] rho);
      req_type w;
      w.cmd = cmd;
      w.angle_index = ang;
      w.cos_value = cosv;
      w.sin_value = sinv;
      w.col = col;
      w.row = row;
      w.lit = lit;
      w.rho_index = rho;
      return w;
   endfunction

   // Lowest angle below the limit that has never been loaded, or -1.
   function automatic int first_unloaded(int unsigned n_ang);
      for (int unsigned i = 0; i < n_ang; i++) begin
         if (!loaded[i]) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Register write with a setup cycle and an access cycle; the access cycle completes while pready is high.
   task automatic write_reg(input logic idx, input int unsigned value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Offers one word, sometimes after a short gap, and returns once it is taken.
   task automatic send_word(input req_type w);
      if (w.cmd == CMD_LOAD) begin
         loaded[w.angle_index] = 1'b1;
      end
      if (!no_idling && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stops offering and waits until every result word has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   // One register setting followed by a stream of mostly well-formed random words.
   task automatic run_phase(input int unsigned angles, input int unsigned rho_bins,
                            input int unsigned words, input bit steady, input bit hold_off);
      req_type     w;
      bit [95:0]   noise;
      int unsigned n_ang;
      int unsigned n_rho;
      int unsigned roll;
      int          gap_angle;
      wait_idle();
      write_reg(REG_ANGLES, angles);
      write_reg(REG_RHO_BINS, rho_bins);
      no_idling <= steady;
      if (hold_off) begin
         stall_requests <= stall_requests + 1;
      end
      n_ang = (angles > DEF_MAX_ANGLES) ? DEF_MAX_ANGLES : angles;
      n_rho = (rho_bins > DEF_MAX_RHO_BINS) ? DEF_MAX_RHO_BINS : rho_bins;
      repeat (words) begin
         noise = {$urandom, $urandom, $urandom};
         w = noise[$bits(req_type)-1:0];
         roll = $urandom_range(99);
         gap_angle = first_unloaded(n_ang);
         if (roll < 25 || (roll < 70 && gap_angle >= 0)) begin
            // A vote must never touch an unloaded angle, so fill the gap first.
            w.cmd = CMD_LOAD;
            if (roll >= 25) begin
               w.angle_index = 8'(gap_angle);
            end
            if ($urandom_range(99) < 85) begin
               w.cos_value = 16'($urandom_range(32768) - 16384);
               w.sin_value = 16'($urandom_range(32768) - 16384);
            end
         end else if (roll < 70) begin
            w.cmd = CMD_VOTE;
            w.lit = ($urandom_range(9) != 0);
         end else begin
            // Reads mostly aim at bins that the current setting can fill.
            w.cmd = CMD_READ;
            if ($urandom_range(99) < 80) begin
               w.angle_index = (n_ang != 0) ? 8'($urandom_range(n_ang - 1)) : 8'd0;
               if (n_rho != 0) begin
                  w.rho_index = 10'($urandom_range(n_rho - 1));
               end
            end
         end
         send_word(w);
      end
   endtask

   // Main sequence.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words: axis-aligned angles, corner pixels, out-of-range sine and cosine.
      write_reg(REG_ANGLES, 4);
      write_reg(REG_RHO_BINS, 1024);
      send_word(pack_word(CMD_LOAD, 8'd0, 16'd16384, 16'd0, '0, '0, 1'b0, '0));
      send_word(pack_word(CMD_LOAD, 8'd1, 16'd0, 16'd16384, '0, '0, 1'b0, '0));
      send_word(pack_word(CMD_LOAD, 8'd2, 16'(-16384), 16'd0, '0, '0, 1'b0, '0));
      send_word(pack_word(CMD_LOAD, 8'd3, 16'd0, 16'(-16384), '0, '0, 1'b0, '0));
      send_word(pack_word(CMD_LOAD, 8'd255, 16'h7FFF, 16'h8000, '0, '0, 1'b0, '0));
      send_word(pack_word(CMD_VOTE, 8'd0, '0, '0, 9'd0, 9'd0, 1'b1, '0));
      send_word(pack_word(CMD_VOTE, 8'd0, '0, '0, 9'd511, 9'd511, 1'b1, '0));
      send_word(pack_word(CMD_VOTE, 8'd0, '0, '0, 9'd511, 9'd511, 1'b0, '0));
      send_word(pack_word(CMD_READ, 8'd0, '0, '0, '0, '0, 1'b0, 10'd512));
      send_word(pack_word(CMD_READ, 8'd0, '0, '0, '0, '0, 1'b0, 10'd1023));
      send_word(pack_word(CMD_READ, 8'd255, '0, '0, '0, '0, 1'b0, 10'd1023));
      send_word(pack_word(CMD_READ, 8'd2, '0, '0, '0, '0, 1'b0, 10'd1));
      wait_idle();
      write_reg(REG_RHO_BINS, 16);
      send_word(pack_word(CMD_VOTE, 8'd0, '0, '0, 9'd511, 9'd0, 1'b1, '0));
      send_word(pack_word(CMD_LOAD, 8'd3, 16'h7FFF, 16'h8000, '0, '0, 1'b0, '0));
      send_word(pack_word(CMD_VOTE, 8'd0, '0, '0, 9'd3, 9'd5, 1'b1, '0));
      send_word(pack_word(CMD_READ, 8'd1, '0, '0, '0, '0, 1'b0, 10'd8));
      send_word(pack_word(CMD_CLEAR, 8'd0, '0, '0, '0, '0, 1'b0, '0));
      send_word(pack_word(CMD_READ, 8'd1, '0, '0, '0, '0, 1'b0, 10'd8));
      send_word(pack_word(CMD_VOTE, 8'd0, '0, '0, 9'd5, 9'd2, 1'b1, '0));
      send_word(pack_word(CMD_READ, 8'd0, '0, '0, '0, '0, 1'b0, 10'd13));

      // Random phases, including saturated and zero settings of both registers.
      run_phase(8, 16, 90, 1'b0, 1'b0);
      run_phase(1, 1, 60, 1'b0, 1'b0);
      run_phase(0, 64, 40, 1'b0, 1'b0);
      run_phase(32, 2047, 90, 1'b0, 1'b0);
      run_phase(64, 200, 100, 1'b0, 1'b1);
      run_phase(511, 0, 80, 1'b0, 1'b0);
      run_phase(256, 1024, 120, 1'b1, 1'b0);
      run_phase(180, 1024, 80, 1'b0, 1'b1);

      // Drain, allow for a full-length vote, then give the verdict.
      wait_idle();
      repeat (300) @(posedge clock);
      if (mismatches == 0 && awaiting == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
